[rtl/box_point_nearest_matcher_assert.svh]
// Assertion macros for the top level of the box and point matcher.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef BOX_POINT_NEAREST_MATCHER_ASSERT_SVH
`define BOX_POINT_NEAREST_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPNM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPNM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bpnm_pkg.sv]
// Package of the box and point matcher: request and result types, codes, constants.
// Used by bpnm_front, bpnm_back and the top level; depends on nothing.
`default_nettype none

package bpnm_pkg;

  localparam int MAX_BOXES_DEF  = 32;
  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 4;

  localparam int IN_CW    = 12;   // coordinate width on the port
  localparam int IDX_W    = 5;    // index width of a result
  localparam int DIST_W   = 18;   // distance width, sixteenths of a pixel
  localparam int RATIO_W  = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 18;
  localparam int OUT_MAX  = 32;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  localparam logic [1:0] MODE_BOX   = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_RATIO   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_LIMIT = 2'd1;

  localparam logic [RATIO_W-1:0] SPREAD_RATIO_RST = 8'd32;

  // Column and row picks of the eight box positions: corners and edge midpoints.
  localparam logic [1:0] POS_XSEL [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd2, 2'd1};
  localparam logic [1:0] POS_YSEL [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};

  typedef enum logic [1:0] {
    KIND_BOX   = 2'd0,
    KIND_POINT = 2'd1,
    KIND_RUN   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [IN_CW-1:0] x_coord;
    logic [IN_CW-1:0] y_coord;
    logic [IN_CW-1:0] box_width;
    logic [IN_CW-1:0] box_height;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] box_index;
    logic [IDX_W-1:0] point_index;
    logic             found;
    logic             last;
  } out_item_t;

  typedef struct packed {
    kind_t    kind;
    in_item_t item;
  } cmd_t;

  typedef struct packed {
    logic [RATIO_W-1:0] spread_ratio;
    logic [DIST_W-1:0]  distance_limit;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/bpnm_front.sv]
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on bpnm_pkg.
`default_nettype none

module bpnm_front import bpnm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_pop,
  output cmd_t     cmd
);

  cmd_t       entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       accept;
  logic       push;
  kind_t      kind;

  assign in_stall  = (fill == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = entry[rp];

  // Requests of the unused mode are taken and dropped here.
  always_comb begin
    kind = KIND_RUN;
    push = accept;
    unique case (in_data.mode)
      MODE_BOX:   kind = KIND_BOX;
      MODE_POINT: kind = KIND_POINT;
      MODE_RUN:   kind = KIND_RUN;
      default:    push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= '{kind: kind, item: in_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= !wp;
      end
      if (cmd_pop) begin
        rp <= !rp;
      end
      if (push && !cmd_pop) begin
        fill <= fill + 2'd1;
      end else if (!push && cmd_pop) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bpnm_isqrt.sv]
// Iterative integer square root, one result bit per cycle, truncating.
// Self-contained; used by bpnm_back for distances and the spread.
`default_nettype none

module bpnm_isqrt #(
  parameter int W = 36
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [W-1:0]   operand,
  output logic           done,
  output logic [W/2-1:0] root
);

  localparam int RW   = W / 2;
  localparam int CNTW = $clog2(RW + 1);

  logic            busy;
  logic [CNTW-1:0] steps;
  logic [W-1:0]    op;
  logic [RW+1:0]   rem;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            ge;

  // The remainder never exceeds twice the partial root, so its low bits suffice.
  assign rem_sh = {rem[RW-1:0], op[W-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        op    <= operand;
        rem   <= '0;
        root  <= '0;
        steps <= CNTW'(RW);
      end else if (busy) begin
        op    <= op << 2;
        rem   <= ge ? rem_sh - trial : rem_sh;
        root  <= {root[RW-2:0], ge};
        steps <= steps - 1'b1;
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bpnm_idiv.sv]
// Iterative restoring divider, one quotient bit per cycle.
// Self-contained; used by bpnm_back for the mean and the variance.
`default_nettype none

module bpnm_idiv #(
  parameter int NW = 42,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int CNTW = $clog2(NW + 1);

  logic            busy;
  logic [CNTW-1:0] steps;
  logic [DW-1:0]   den;
  logic [DW-1:0]   rem;
  logic [DW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem, quotient[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        quotient <= dividend;
        den      <= divisor;
        rem      <= '0;
        steps    <= CNTW'(NW);
      end else if (busy) begin
        rem      <= ge ? DW'(rem_sh - {1'b0, den}) : rem_sh[DW-1:0];
        quotient <= {quotient[NW-2:0], ge};
        steps    <= steps - 1'b1;
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/bpnm_back.sv]
// Back end: box and point stores, the matching sequencer, outlier statistics and emission.
// Depends on bpnm_pkg, bpnm_isqrt and bpnm_idiv.
`default_nettype none

module bpnm_back import bpnm_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      cmd,
  input  logic      cmd_valid,
  output logic      cmd_pop,
  input  cfg_t      cfg,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int MAXQ  = (MAX_BOXES > MAX_POINTS) ? MAX_BOXES : MAX_POINTS;
  localparam int BIW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int PIW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int QIW   = (MAXQ > 1) ? $clog2(MAXQ) : 1;
  localparam int BCW   = $clog2(MAX_BOXES + 1);
  localparam int PCW   = $clog2(MAX_POINTS + 1);
  localparam int QCW   = $clog2(MAXQ + 1);
  localparam int CW    = COORD_BITS;
  localparam int KEEP  = (CW < IN_CW) ? CW : IN_CW;
  localparam int PW    = CW + 1;
  localparam int SQW   = 2 * PW + 1;
  localparam int SHW   = SQW + 2 * FRAC_BITS;
  localparam int VARW  = 2 * DIST_W;
  localparam int SUMW  = DIST_W + QCW;
  localparam int DEVW  = VARW + QCW;
  localparam int RAW0  = (SHW > VARW) ? SHW : VARW;
  localparam int RAW   = RAW0 + (RAW0 % 2);
  localparam int RTW   = RAW / 2;
  localparam int PRW   = RATIO_W + DIST_W;
  localparam int THRW  = PRW - 4 + 1;
  localparam int OCW   = $clog2(OUT_MAX + 1);
  localparam int PAIRW = BIW + PIW;

  typedef enum logic [19:0] {
    S_IDLE  = 20'h00001,
    S_INIT  = 20'h00002,
    S_PAIR  = 20'h00004,
    S_RD    = 20'h00008,
    S_POS   = 20'h00010,
    S_ROOT  = 20'h00020,
    S_QRD   = 20'h00040,
    S_QUPD  = 20'h00080,
    S_SUM   = 20'h00100,
    S_MEAN  = 20'h00200,
    S_DEV   = 20'h00400,
    S_VAR   = 20'h00800,
    S_STD   = 20'h01000,
    S_THR1  = 20'h02000,
    S_THR2  = 20'h04000,
    S_ERD   = 20'h08000,
    S_ECHK  = 20'h10000,
    S_EPUSH = 20'h20000,
    S_EFIN  = 20'h40000,
    S_SPARE = 20'h80000
  } state_t;

  state_t state;

  // Stores
  logic [4*CW-1:0]   bmem  [MAX_BOXES];
  logic [2*CW-1:0]   pmem  [MAX_POINTS];
  logic [DIST_W-1:0] qbd   [MAXQ];
  logic [QIW-1:0]    qrow  [MAXQ];
  logic [DIST_W-1:0] rdist [MAXQ];
  logic [PAIRW-1:0]  rpair [MAXQ];

  logic [4*CW-1:0]   b_rd;
  logic [2*CW-1:0]   p_rd;
  logic [DIST_W-1:0] qbd_rd;
  logic [QIW-1:0]    qrow_rd;
  logic [DIST_W-1:0] rdist_rd;
  logic [PAIRW-1:0]  rpair_rd;

  logic [BCW-1:0]  box_count;
  logic [PCW-1:0]  point_count;
  logic [QCW-1:0]  row_count;
  logic [MAXQ-1:0] taken;
  logic            pts_search;
  logic [QCW-1:0]  ns;
  logic [QCW-1:0]  nq;
  logic [QCW-1:0]  s;
  logic [QCW-1:0]  q;
  logic [QCW-1:0]  r;
  logic [QCW-1:0]  bi;
  logic [QCW-1:0]  pi;

  logic [3:0]        k;
  logic              v1;
  logic              v2;
  logic [PW-1:0]     dx_r;
  logic [PW-1:0]     dy_r;
  logic [SQW-1:0]    sq_r;
  logic [SQW-1:0]    min_sq;
  logic              min_v;
  logic [DIST_W-1:0] best;
  logic              best_v;
  logic [QIW-1:0]    assoc;

  logic [SUMW-1:0]   dsum;
  logic [DEVW-1:0]   dev_sum;
  logic              rv;
  logic              ev;
  logic              sv;
  logic [DIST_W-1:0] e_r;
  logic [VARW-1:0]   esq_r;
  logic [DIST_W-1:0] mean;
  logic [DIST_W-1:0] stdv;
  logic [PRW-1:0]    prod;
  logic [THRW-1:0]   thr;

  logic             pend;
  logic [PAIRW-1:0] pend_pair;
  logic [OCW-1:0]   cnt;

  // Load path
  logic [CW-1:0] in_x;
  logic [CW-1:0] in_y;
  logic [CW-1:0] in_w;
  logic [CW-1:0] in_h;
  logic          b_we;
  logic          p_we;

  assign cmd_pop = (state == S_IDLE) && cmd_valid;
  assign in_x = CW'(cmd.item.x_coord[KEEP-1:0]);
  assign in_y = CW'(cmd.item.y_coord[KEEP-1:0]);
  assign in_w = CW'(cmd.item.box_width[KEEP-1:0]);
  assign in_h = CW'(cmd.item.box_height[KEEP-1:0]);
  assign b_we = cmd_pop && (cmd.kind == KIND_BOX) && (box_count < BCW'(MAX_BOXES));
  assign p_we = cmd_pop && (cmd.kind == KIND_POINT) && (point_count < PCW'(MAX_POINTS));

  assign bi = pts_search ? q : s;
  assign pi = pts_search ? s : q;

  always_ff @(posedge clk) begin
    if (b_we) begin
      bmem[box_count[BIW-1:0]] <= {in_x, in_y, in_w, in_h};
    end
    b_rd <= bmem[bi[BIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[point_count[PIW-1:0]] <= {in_x, in_y};
    end
    p_rd <= pmem[pi[PIW-1:0]];
  end

  // Position pipeline: pick a corner or midpoint, take offsets, square, keep the least.
  logic [CW-1:0] bx;
  logic [CW-1:0] by;
  logic [CW-1:0] bw;
  logic [CW-1:0] bh;
  logic [PW-1:0] px;
  logic [PW-1:0] py;
  logic [PW-1:0] ax;
  logic [PW-1:0] ay;

  assign bx = b_rd[4*CW-1 -: CW];
  assign by = b_rd[3*CW-1 -: CW];
  assign bw = b_rd[2*CW-1 -: CW];
  assign bh = b_rd[CW-1:0];
  assign px = PW'(p_rd[2*CW-1 -: CW]);
  assign py = PW'(p_rd[CW-1:0]);

  always_comb begin
    unique case (POS_XSEL[k[2:0]])
      2'd0:    ax = PW'(bx);
      2'd1:    ax = PW'(bx) + PW'(bw[CW-1:1]);
      default: ax = PW'(bx) + PW'(bw);
    endcase
    unique case (POS_YSEL[k[2:0]])
      2'd0:    ay = PW'(by);
      2'd1:    ay = PW'(by) + PW'(bh[CW-1:1]);
      default: ay = PW'(by) + PW'(bh);
    endcase
  end

  always_ff @(posedge clk) begin
    dx_r <= (ax > px) ? ax - px : px - ax;
    dy_r <= (ay > py) ? ay - py : py - ay;
    sq_r <= SQW'(dx_r * dx_r) + SQW'(dy_r * dy_r);
  end

  // Shared arithmetic units
  logic            sq_start;
  logic [RAW-1:0]  sq_op;
  logic            sq_done;
  logic [RTW-1:0]  sq_root;
  logic            dv_start;
  logic [DEVW-1:0] dv_num;
  logic            dv_done;
  logic [DEVW-1:0] dv_quot;
  logic            sweep_end;
  logic            dev_end;
  logic [DIST_W-1:0] pair_dist;

  assign sweep_end = (r == row_count) && !rv;
  assign dev_end   = sweep_end && !ev && !sv;
  assign sq_start  = ((state == S_POS) && (k == 4'd10)) || ((state == S_VAR) && dv_done);
  assign sq_op     = (state == S_POS) ? (RAW'(min_sq) << (2 * FRAC_BITS))
                                      : RAW'(dv_quot[VARW-1:0]);
  assign dv_start  = ((state == S_SUM) && sweep_end) || ((state == S_DEV) && dev_end);
  assign dv_num    = (state == S_SUM) ? DEVW'(dsum) : dev_sum;
  assign pair_dist = (sq_root > RTW'(DIST_MAX)) ? DIST_MAX : sq_root[DIST_W-1:0];

  bpnm_isqrt #(.W(RAW)) u_isqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .operand (sq_op),
    .done    (sq_done),
    .root    (sq_root)
  );

  bpnm_idiv #(.NW(DEVW), .DW(QCW)) u_idiv (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (row_count),
    .done     (dv_done),
    .quotient (dv_quot)
  );

  // Per-queried-entry records and the row table
  logic             q_we;
  logic             r_we;
  logic [QIW-1:0]   r_waddr;
  logic [PAIRW-1:0] pair_now;
  logic             is_new;
  logic             kept;

  assign is_new   = !taken[assoc];
  assign q_we     = (state == S_QUPD) && (is_new || (best < qbd_rd));
  assign r_we     = q_we;
  assign r_waddr  = is_new ? row_count[QIW-1:0] : qrow_rd;
  assign pair_now = pts_search ? {BIW'(assoc), PIW'(s)} : {BIW'(s), PIW'(assoc)};
  assign kept     = (THRW'(rdist_rd) <= thr) && (rdist_rd <= cfg.distance_limit);

  always_ff @(posedge clk) begin
    if (q_we) begin
      qbd[assoc] <= best;
      if (is_new) begin
        qrow[assoc] <= row_count[QIW-1:0];
      end
    end
    qbd_rd  <= qbd[assoc];
    qrow_rd <= qrow[assoc];
  end

  always_ff @(posedge clk) begin
    if (r_we) begin
      rdist[r_waddr] <= best;
      rpair[r_waddr] <= pair_now;
    end
    rdist_rd <= rdist[r[QIW-1:0]];
    rpair_rd <= rpair[r[QIW-1:0]];
  end

  // Output register
  logic      slot_free;
  logic      out_load;
  out_item_t out_next;

  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    out_load = 1'b0;
    out_next = '{box_index: IDX_W'(pend_pair[PAIRW-1 -: BIW]),
                 point_index: IDX_W'(pend_pair[PIW-1:0]),
                 found: 1'b1, last: 1'b0};
    if (slot_free && (state == S_EPUSH)) begin
      out_load = 1'b1;
    end else if (slot_free && (state == S_EFIN)) begin
      out_load      = 1'b1;
      out_next.last = 1'b1;
      if (!pend) begin
        out_next = '{box_index: '0, point_index: '0, found: 1'b0, last: 1'b1};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      box_count   <= '0;
      point_count <= '0;
      row_count   <= '0;
      taken       <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      rv          <= 1'b0;
      ev          <= 1'b0;
      sv          <= 1'b0;
      pend        <= 1'b0;
      cnt         <= '0;
      k           <= '0;
      s           <= '0;
      q           <= '0;
      r           <= '0;
      min_v       <= 1'b0;
      best_v      <= 1'b0;
    end else begin
      v1 <= (state == S_POS) && (k < 4'd8);
      v2 <= v1;
      rv <= ((state == S_SUM) || (state == S_DEV)) && (r < row_count);
      ev <= (state == S_DEV) && rv;
      sv <= ev;
      if (v2 && (!min_v || (sq_r < min_sq))) begin
        min_sq <= sq_r;
        min_v  <= 1'b1;
      end
      if (rv) begin
        dsum <= (state == S_SUM) ? dsum + SUMW'(rdist_rd) : dsum;
        e_r  <= (rdist_rd > mean) ? rdist_rd - mean : mean - rdist_rd;
      end
      esq_r <= VARW'(e_r * e_r);
      if (sv) begin
        dev_sum <= dev_sum + DEVW'(esq_r);
      end

      unique case (state)
        S_IDLE: begin
          if (b_we) begin
            box_count <= box_count + 1'b1;
          end
          if (p_we) begin
            point_count <= point_count + 1'b1;
          end
          if (cmd_pop && (cmd.kind == KIND_RUN)) begin
            state <= S_INIT;
          end
        end
        S_INIT: begin
          pts_search <= (QCW'(point_count) <= QCW'(box_count));
          ns         <= (QCW'(point_count) <= QCW'(box_count)) ? QCW'(point_count)
                                                               : QCW'(box_count);
          nq         <= (QCW'(point_count) <= QCW'(box_count)) ? QCW'(box_count)
                                                               : QCW'(point_count);
          taken      <= '0;
          row_count  <= '0;
          dsum       <= '0;
          dev_sum    <= '0;
          pend       <= 1'b0;
          cnt        <= '0;
          s          <= '0;
          state      <= S_PAIR;
        end
        S_PAIR: begin
          q      <= '0;
          best_v <= 1'b0;
          r      <= '0;
          if (s != ns) begin
            state <= S_RD;
          end else if (row_count == '0) begin
            state <= S_EFIN;
          end else begin
            state <= S_SUM;
          end
        end
        S_RD: begin
          min_v <= 1'b0;
          k     <= '0;
          state <= S_POS;
        end
        S_POS: begin
          k <= k + 4'd1;
          if (k == 4'd10) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sq_done) begin
            if (!best_v || (pair_dist < best)) begin
              best   <= pair_dist;
              best_v <= 1'b1;
              assoc  <= q[QIW-1:0];
            end
            if (q + 1'b1 == nq) begin
              state <= S_QRD;
            end else begin
              q     <= q + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_QRD: begin
          state <= S_QUPD;
        end
        S_QUPD: begin
          if (is_new) begin
            taken[assoc] <= 1'b1;
            row_count    <= row_count + 1'b1;
          end
          s     <= s + 1'b1;
          state <= S_PAIR;
        end
        S_SUM: begin
          if (r < row_count) begin
            r <= r + 1'b1;
          end
          if (sweep_end) begin
            state <= S_MEAN;
          end
        end
        S_MEAN: begin
          r <= '0;
          if (dv_done) begin
            mean  <= dv_quot[DIST_W-1:0];
            state <= S_DEV;
          end
        end
        S_DEV: begin
          if (r < row_count) begin
            r <= r + 1'b1;
          end
          if (dev_end) begin
            state <= S_VAR;
          end
        end
        S_VAR: begin
          if (dv_done) begin
            state <= S_STD;
          end
        end
        S_STD: begin
          if (sq_done) begin
            stdv  <= sq_root[DIST_W-1:0];
            state <= S_THR1;
          end
        end
        S_THR1: begin
          prod  <= PRW'(cfg.spread_ratio * stdv);
          state <= S_THR2;
        end
        S_THR2: begin
          thr   <= THRW'(mean) + THRW'(prod >> 4);
          r     <= '0;
          state <= S_ERD;
        end
        S_ERD: begin
          state <= (r == row_count) ? S_EFIN : S_ECHK;
        end
        S_ECHK: begin
          if (kept && pend) begin
            state <= S_EPUSH;
          end else begin
            if (kept) begin
              pend      <= 1'b1;
              pend_pair <= rpair_rd;
              cnt       <= cnt + 1'b1;
            end
            if (kept && (cnt + 1'b1 == OCW'(OUT_MAX))) begin
              state <= S_EFIN;
            end else begin
              r     <= r + 1'b1;
              state <= S_ERD;
            end
          end
        end
        S_EPUSH: begin
          if (slot_free) begin
            pend_pair <= rpair_rd;
            cnt       <= cnt + 1'b1;
            if (cnt + 1'b1 == OCW'(OUT_MAX)) begin
              state <= S_EFIN;
            end else begin
              r     <= r + 1'b1;
              state <= S_ERD;
            end
          end
        end
        S_EFIN: begin
          if (slot_free) begin
            box_count   <= '0;
            point_count <= '0;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/box_point_nearest_matcher.sv]
// Box and point nearest matcher, top level: configuration registers, front and back.
// A load request enters the queue when accepted, leaves it when the back end is idle and
// is stored as it leaves. A run searches, for each entry of the smaller set, the nearest
// entry of the larger set with a square root per pair, then makes two row sweeps, two
// divisions and a square root, then reads and checks each row and emits the kept ones.
// One request at a time; reset is synchronous, active high, empties the queue.
`default_nettype none

module box_point_nearest_matcher import bpnm_pkg::*; #(
  parameter int MAX_BOXES  = MAX_BOXES_DEF,
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.spread_ratio   <= SPREAD_RATIO_RST;
      cfg.distance_limit <= DIST_MAX;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SPREAD_RATIO:   cfg.spread_ratio   <= cfg_data[RATIO_W-1:0];
        REG_DISTANCE_LIMIT: cfg.distance_limit <= cfg_data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

  bpnm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  bpnm_back #(
    .MAX_BOXES  (MAX_BOXES),
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`include "box_point_nearest_matcher_assert.svh"

  // The back end never takes a request from an empty queue.
  `BPNM_ASSERT_NOW(a_pop_has_request, cmd_pop, cmd_valid, "request taken from empty queue")
  // An empty queue has room, so the input side is never held off.
  `BPNM_ASSERT_NOW(a_empty_no_stall, !cmd_valid, !in_stall, "stall with an empty queue")
  // A result without a match is always the closing result of its run.
  `BPNM_ASSERT_NOW(a_nomatch_last, out_valid && !out_data.found, out_data.last,
                   "no-match result without last")
  // A stalled result stays offered and unchanged.
  `BPNM_ASSERT_NEXT(a_hold_when_stalled, out_valid && out_stall,
                    out_valid && $stable(out_data), "result changed while stalled")

endmodule

`default_nettype wire
